>>> hw/rtl/chunk_directory_parser_top_assert.svh
// Assertion macros shared by the chunk directory parser modules.
// Expect clock aclk and active-low reset aresetn in the including module.
`ifndef CHUNK_DIRECTORY_PARSER_TOP_ASSERT_SVH
`define CHUNK_DIRECTORY_PARSER_TOP_ASSERT_SVH

// Same-cycle implication.
`define CDP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CDP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/cdp_pkg.sv
// Package for the chunk directory parser: phases, result record, chunk tags.
// No dependencies; used by cdp_parser, cdp_out_queue and the top level.
`timescale 1ns / 1ps

package cdp_pkg;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_COUNT,
        PH_ENTRIES,
        PH_SKIP,
        PH_TRAIL,
        PH_ERROR,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ENTRY,
        KIND_COUNT,
        KIND_ERROR,
        KIND_DONE
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_SIZE,
        ERR_SHORT,
        ERR_LIMIT
    } err_t;

    localparam logic [2:0] TBL_ROOMS    = 3'd0;
    localparam logic [2:0] TBL_SCRIPTS  = 3'd1;
    localparam logic [2:0] TBL_SOUNDS   = 3'd2;
    localparam logic [2:0] TBL_COSTUMES = 3'd3;
    localparam logic [2:0] TBL_GLOBALS  = 3'd4;

    localparam logic [15:0] TAG_NAMES    = 16'h4E52;
    localparam logic [15:0] TAG_ROOMS    = 16'h5230;
    localparam logic [15:0] TAG_SCRIPTS  = 16'h5330;
    localparam logic [15:0] TAG_SOUNDS   = 16'h4E30;
    localparam logic [15:0] TAG_COSTUMES = 16'h4330;
    localparam logic [15:0] TAG_GLOBALS  = 16'h4F30;

    // output queue geometry
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  table_id;
        logic [10:0] entry_index;
        logic [7:0]  disk_number;
        logic [31:0] entry_value;
        err_t        error_code;
        logic        last;
    } result_t;

    // up to two results per accepted byte; v1 only with v0
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] id;
    } tbl_sel_t;

    function automatic tbl_sel_t tag_to_table(input logic [15:0] tag);
        tbl_sel_t s;
        s.hit = 1'b1;
        s.id  = TBL_ROOMS;
        unique case (tag)
            TAG_ROOMS:    s.id = TBL_ROOMS;
            TAG_SCRIPTS:  s.id = TBL_SCRIPTS;
            TAG_SOUNDS:   s.id = TBL_SOUNDS;
            TAG_COSTUMES: s.id = TBL_COSTUMES;
            TAG_GLOBALS:  s.id = TBL_GLOBALS;
            TAG_NAMES:    s.hit = 1'b0;
            default:      s.hit = 1'b0;
        endcase
        return s;
    endfunction

    function automatic result_t make_res(input kind_t kind, input logic [2:0] tbl,
                                         input logic [10:0] idx, input logic [7:0] disk,
                                         input logic [31:0] value, input err_t err);
        result_t r;
        r.kind        = kind;
        r.table_id    = tbl;
        r.entry_index = idx;
        r.disk_number = disk;
        r.entry_value = value;
        r.error_code  = err;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

>>> hw/rtl/chunk_directory_parser_top.sv
// Chunk directory parser top level: stream ports, parser and result queue.
// Depends on cdp_pkg, cdp_parser and cdp_out_queue.
`timescale 1ns / 1ps

// Usage:
//   s_* channel carries the index file one byte per transfer, in file order.
//   m_* channel carries results: counts, directory entries, errors and done.
//   Write the total byte count through cfg_we/cfg_wdata before streaming;
//   each write also restarts the walk from the first chunk. Write only while
//   no byte is in flight and all its results are taken.
// Timing:
//   A byte is taken every cycle while s_tready is high; its results enter the
//   queue at the accepting edge. Sustained rate is one byte per cycle while
//   it has room, set by the combinational parse step and the 4-entry queue.
//   A byte yields at most two results (the second is always done), so the
//   queue must hold two free slots: s_tready drops while it holds 3 or more.
// Stall: when m_tready is low results wait in the queue, in order; the input
//   side keeps taking bytes until the queue is near full, then backpressures.
// Reset: aresetn low (synchronous) clears the length to zero and empties the
//   queue. With length zero every byte is taken and dropped without results.
//   After an error or the final byte, further bytes are taken and dropped.
module chunk_directory_parser_top import cdp_pkg::*; #(
    parameter int ROOM_LIMIT    = 256,
    parameter int SCRIPT_LIMIT  = 512,
    parameter int SOUND_LIMIT   = 512,
    parameter int COSTUME_LIMIT = 512,
    parameter int GLOBAL_LIMIT  = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: total stream length in bytes
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    // byte input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] stream_byte
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [2:0] table_id, [13:3] entry_index,
                                   // [21:14] disk_number, [53:22] entry_value,
                                   // [55:54] error_code
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    output logic        m_tlast    // last result of its input byte
);

    push_t   push;
    result_t head;
    logic    s_accept;

    assign s_accept = s_tvalid && s_tready;

    cdp_parser #(
        .ROOM_LIMIT    (ROOM_LIMIT),
        .SCRIPT_LIMIT  (SCRIPT_LIMIT),
        .SOUND_LIMIT   (SOUND_LIMIT),
        .COSTUME_LIMIT (COSTUME_LIMIT),
        .GLOBAL_LIMIT  (GLOBAL_LIMIT)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_accept (s_accept),
        .in_byte   (s_tdata),
        .push      (push)
    );

    cdp_out_queue u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (head)
    );

    // pack the head result onto the master side
    assign m_tdata = {head.error_code, head.entry_value, head.disk_number,
                      head.entry_index, head.table_id};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

>>> hw/rtl/cdp_out_queue.sv
// Four-entry result queue between the parser and the master stream side.
// Depends on cdp_pkg and chunk_directory_parser_top_assert.svh.
`timescale 1ns / 1ps
`include "chunk_directory_parser_top_assert.svh"

module cdp_out_queue import cdp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    result_t            mem_reg [OQ_DEPTH];
    logic [OQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OQ_AW:0]     count_reg, count_next;
    logic [OQ_AW-1:0]   wr_ptr_plus1;
    logic [OQ_AW:0]     push_cnt;
    logic               pop;

    // room for two results is needed before taking another byte
    assign in_ready  = count_reg <= (OQ_AW+1)'(OQ_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_res   = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign push_cnt     = (OQ_AW+1)'(push.v0) + (OQ_AW+1)'(push.v1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_cnt[OQ_AW-1:0];
        rd_ptr_next = rd_ptr_reg + (OQ_AW)'(pop);
        count_next  = count_reg + push_cnt - (OQ_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.v0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.v1) begin
            mem_reg[wr_ptr_plus1] <= push.r1;
        end
    end

    `CDP_ASSERT_NOW(a_room_for_two, push.v0, count_reg <= (OQ_AW+1)'(OQ_DEPTH - 2), "push without room")
    `CDP_ASSERT_NOW(a_ptr_count, 1'b1, count_reg[OQ_AW-1:0] == (OQ_AW)'(wr_ptr_reg - rd_ptr_reg), "pointers disagree with count")
    `CDP_ASSERT_NEXT(a_drain, pop && !push.v0, count_reg == $past(count_reg) - 1'b1, "pop did not drain one entry")

endmodule

>>> hw/rtl/cdp_parser.sv
// Byte-at-a-time chunk walker: header, count and entry assembly, checks.
// Depends on cdp_pkg and chunk_directory_parser_top_assert.svh.
`timescale 1ns / 1ps
`include "chunk_directory_parser_top_assert.svh"

module cdp_parser import cdp_pkg::*; #(
    parameter int ROOM_LIMIT    = 256,
    parameter int SCRIPT_LIMIT  = 512,
    parameter int SOUND_LIMIT   = 512,
    parameter int COSTUME_LIMIT = 512,
    parameter int GLOBAL_LIMIT  = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_accept,
    input  logic [7:0]  in_byte,
    output push_t       push
);

    logic [31:0] len_reg;
    logic [31:0] pos_reg,       pos_next;
    logic [31:0] chunk_end_reg, chunk_end_next;
    logic [31:0] body_reg,      body_next;
    phase_t      phase_reg,     phase_next;
    logic [2:0]  table_reg,     table_next;
    logic [11:0] left_reg,      left_next;
    logic [10:0] index_reg,     index_next;
    logic [2:0]  fbc_reg,       fbc_next;
    logic [39:0] asm_reg,       asm_next;

    phase_t      cur_ph;
    logic        active;
    tbl_sel_t    sel;
    logic [31:0] size_w, start_w;
    logic [32:0] end_w;
    logic [15:0] cnt_w, limit_w;
    logic [18:0] need_w;
    logic        last_entry_byte;

    always_comb begin
        unique case (table_reg)
            TBL_ROOMS:    limit_w = 16'(ROOM_LIMIT);
            TBL_SCRIPTS:  limit_w = 16'(SCRIPT_LIMIT);
            TBL_SOUNDS:   limit_w = 16'(SOUND_LIMIT);
            TBL_COSTUMES: limit_w = 16'(COSTUME_LIMIT);
            default:      limit_w = 16'(GLOBAL_LIMIT);
        endcase
    end

    always_comb begin
        pos_next       = pos_reg;
        chunk_end_next = chunk_end_reg;
        body_next      = body_reg;
        phase_next     = phase_reg;
        table_next     = table_reg;
        left_next      = left_reg;
        index_next     = index_reg;
        fbc_next       = fbc_reg;
        asm_next       = asm_reg;
        push           = '0;

        sel     = tag_to_table({in_byte, asm_reg[39:32]});
        size_w  = asm_reg[31:0];
        start_w = pos_reg - 32'd5;
        end_w   = {1'b0, start_w} + {1'b0, size_w};
        cnt_w   = {in_byte, asm_reg[7:0]};
        need_w  = {1'b0, cnt_w, 2'b00} + {3'b000, cnt_w} + 19'd2;
        last_entry_byte = (table_reg == TBL_GLOBALS) ? (fbc_reg == 3'd3) : (fbc_reg == 3'd4);

        active = in_accept && (pos_reg < len_reg) && (phase_reg != PH_DONE);

        // fewer than a header's worth left at a chunk boundary: skip to end
        cur_ph = phase_reg;
        if (phase_reg == PH_HEADER && fbc_reg == 3'd0 && (len_reg - pos_reg) < 32'd6) begin
            cur_ph = PH_TRAIL;
        end

        if (active) begin
            phase_next = cur_ph;
            unique case (cur_ph)
                PH_HEADER: begin
                    if (fbc_reg == 3'd5) begin
                        fbc_next = '0;
                        if (size_w < 32'd6 || end_w > {1'b0, len_reg}) begin
                            push.v0 = 1'b1;
                            push.r0 = make_res(KIND_ERROR, '0, '0, '0, '0, ERR_SIZE);
                            phase_next = PH_ERROR;
                        end else begin
                            chunk_end_next = end_w[31:0];
                            body_next      = size_w - 32'd6;
                            if (sel.hit) begin
                                table_next = sel.id;
                                if (body_next < 32'd2) begin
                                    push.v0 = 1'b1;
                                    push.r0 = make_res(KIND_ERROR, '0, '0, '0, '0, ERR_SHORT);
                                    phase_next = PH_ERROR;
                                end else begin
                                    phase_next = PH_COUNT;
                                end
                            end else begin
                                phase_next = PH_SKIP;
                            end
                        end
                    end else begin
                        asm_next[{fbc_reg, 3'b000} +: 8] = in_byte;
                        fbc_next = fbc_reg + 3'd1;
                    end
                end
                PH_COUNT: begin
                    if (fbc_reg == 3'd1) begin
                        fbc_next = '0;
                        if (cnt_w > limit_w) begin
                            push.v0 = 1'b1;
                            push.r0 = make_res(KIND_ERROR, '0, '0, '0, '0, ERR_LIMIT);
                            phase_next = PH_ERROR;
                        end else if (table_reg != TBL_GLOBALS &&
                                     body_reg < {13'd0, need_w}) begin
                            push.v0 = 1'b1;
                            push.r0 = make_res(KIND_ERROR, '0, '0, '0, '0, ERR_SHORT);
                            phase_next = PH_ERROR;
                        end else begin
                            push.v0 = 1'b1;
                            push.r0 = make_res(KIND_COUNT, table_reg, '0, '0,
                                               {16'd0, cnt_w}, ERR_NONE);
                            left_next  = cnt_w[11:0];
                            index_next = '0;
                            phase_next = (cnt_w != '0) ? PH_ENTRIES : PH_SKIP;
                        end
                    end else begin
                        asm_next[{fbc_reg, 3'b000} +: 8] = in_byte;
                        fbc_next = fbc_reg + 3'd1;
                    end
                end
                PH_ENTRIES: begin
                    if (last_entry_byte) begin
                        push.v0 = 1'b1;
                        if (table_reg == TBL_GLOBALS) begin
                            push.r0 = make_res(KIND_ENTRY, TBL_GLOBALS, index_reg, '0,
                                               {in_byte, asm_reg[23:0]}, ERR_NONE);
                        end else begin
                            push.r0 = make_res(KIND_ENTRY, table_reg, index_reg, asm_reg[7:0],
                                               {in_byte, asm_reg[31:8]}, ERR_NONE);
                        end
                        fbc_next   = '0;
                        index_next = index_reg + 11'd1;
                        left_next  = left_reg - 12'd1;
                        if (left_reg == 12'd1) begin
                            phase_next = PH_SKIP;
                        end
                    end else begin
                        asm_next[{fbc_reg, 3'b000} +: 8] = in_byte;
                        fbc_next = fbc_reg + 3'd1;
                    end
                end
                default: begin
                end
            endcase

            pos_next = pos_reg + 32'd1;

            if ((phase_next == PH_COUNT || phase_next == PH_ENTRIES || phase_next == PH_SKIP)
                && pos_next == chunk_end_next) begin
                phase_next = PH_HEADER;
                fbc_next   = '0;
            end

            if (pos_next == len_reg) begin
                if (phase_next != PH_ERROR) begin
                    if (push.v0) begin
                        push.v1 = 1'b1;
                        push.r1 = make_res(KIND_DONE, '0, '0, '0, '0, ERR_NONE);
                    end else begin
                        push.v0 = 1'b1;
                        push.r0 = make_res(KIND_DONE, '0, '0, '0, '0, ERR_NONE);
                    end
                end
                phase_next = PH_DONE;
            end

            if (push.v1) begin
                push.r1.last = 1'b1;
            end else if (push.v0) begin
                push.r0.last = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= '0;
            pos_reg       <= '0;
            chunk_end_reg <= '0;
            body_reg      <= '0;
            phase_reg     <= PH_HEADER;
            table_reg     <= '0;
            left_reg      <= '0;
            index_reg     <= '0;
            fbc_reg       <= '0;
        end else if (cfg_we) begin
            // new length restarts the walk
            len_reg       <= cfg_wdata;
            pos_reg       <= '0;
            chunk_end_reg <= '0;
            body_reg      <= '0;
            phase_reg     <= PH_HEADER;
            table_reg     <= '0;
            left_reg      <= '0;
            index_reg     <= '0;
            fbc_reg       <= '0;
        end else begin
            pos_reg       <= pos_next;
            chunk_end_reg <= chunk_end_next;
            body_reg      <= body_next;
            phase_reg     <= phase_next;
            table_reg     <= table_next;
            left_reg      <= left_next;
            index_reg     <= index_next;
            fbc_reg       <= fbc_next;
        end
    end

    // byte lanes are always written before being read
    always_ff @(posedge aclk) begin
        asm_reg <= asm_next;
    end

    `CDP_ASSERT_NOW(a_second_is_done, push.v1, push.v0 && push.r1.kind == KIND_DONE && push.r0.kind != KIND_ERROR, "bad second result")
    `CDP_ASSERT_NOW(a_quiet_after_end, phase_reg == PH_ERROR || phase_reg == PH_DONE, !push.v0, "result after error or end")
    `CDP_ASSERT_NEXT(a_done_sticks, phase_reg == PH_DONE && !cfg_we, phase_reg == PH_DONE, "left done without restart")

endmodule
